[sv/tss_pkg.sv]
// ----------------------------------------------------------------------------
// tss_pkg: shared types and codes of the task scheduler
// Item layouts, task table entry, function and task state codes.
// ----------------------------------------------------------------------------
package tss_pkg;

	// function codes of an input item
	localparam logic [1:0] FN_TICK  = 2'd0;
	localparam logic [1:0] FN_SCHED = 2'd1;
	localparam logic [1:0] FN_WRITE = 2'd2;
	localparam logic [1:0] FN_SLEEP = 2'd3;

	// task states
	localparam logic [2:0] ST_INVALID = 3'd0;
	localparam logic [2:0] ST_STOPPED = 3'd1;
	localparam logic [2:0] ST_UNRUN   = 3'd2;
	localparam logic [2:0] ST_READY   = 3'd3;
	localparam logic [2:0] ST_DELAYED = 3'd4;

	// configuration register indexes
	localparam int         CFG_INDEX_W       = 1;
	localparam logic [0:0] CFG_PRIORITY_MODE = 1'b0;
	localparam logic [0:0] CFG_PREEMPT       = 1'b1;

	// only the leading entries are counted down by a tick
	localparam int TICKED_TASKS = 12;

	typedef struct packed {
		logic [1:0]  func;
		logic [3:0]  task_index;
		logic [2:0]  new_state;
		logic [2:0]  new_priority;
		logic [31:0] sleep_ticks;
	} in_t;

	typedef struct packed {
		logic [3:0] chosen_task;
		logic       chosen_valid;
		logic       none_ready;
		logic       switch_request;
	} out_t;

	typedef struct packed {
		logic [2:0]  state;
		logic [2:0]  prio;
		logic [31:0] ticks;
	} entry_t;

	typedef struct packed {
		logic scan;
		logic first;
		logic priority_mode;
	} head_ctl_t;

endpackage

[sv/tss_cell.sv]
// ----------------------------------------------------------------------------
// tss_cell: one task table entry in the rotating ring
// Takes its neighbor's entry on every shift, or is marked ready by a pick.
// ----------------------------------------------------------------------------
module tss_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  logic            set_ready,
	input  tss_pkg::entry_t next,
	output tss_pkg::entry_t entry
);
	import tss_pkg::*;

	entry_t entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (shift) begin
			entry_q <= next;
		end else if (set_ready) begin
			entry_q.state <= ST_READY;
		end
	end

	assign entry = entry_q;

endmodule

[sv/tss_head.sv]
// ----------------------------------------------------------------------------
// tss_head: update unit at the head of the ring
// Applies tick, write and sleep items to the passing entry and tracks the
// best schedule candidate over one full rotation.
// ----------------------------------------------------------------------------
module tss_head #(
	parameter int TASK_COUNT      = 16,
	parameter int PRIORITY_LEVELS = 8,
	localparam int IW             = $clog2(TASK_COUNT)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tss_pkg::head_ctl_t ctl,
	input  tss_pkg::in_t       item,
	input  logic [IW-1:0]      step,
	input  logic [IW-1:0]      last,
	input  tss_pkg::entry_t    entry_in,
	output tss_pkg::entry_t    entry_out,
	output logic               found,
	output logic [IW-1:0]      pick
);
	import tss_pkg::*;

	localparam int TICK_LIM = (TICKED_TASKS < TASK_COUNT) ? TICKED_TASKS : TASK_COUNT;

	logic          found_q;
	logic [3:0]    best_key_q;
	logic [IW-1:0] best_idx_q;
	logic [31:0]   dec;
	logic          runnable;
	logic          eligible;
	logic [3:0]    key;
	logic          found_eff;
	logic          take;

	always_comb begin
		entry_out = entry_in;
		dec       = (entry_in.ticks != 32'd0) ? entry_in.ticks - 32'd1 : 32'd0;
		unique case (item.func)
			FN_TICK: begin
				if (32'(step) < TICK_LIM && entry_in.state == ST_DELAYED) begin
					entry_out.ticks = dec;
					if (dec == 32'd0) entry_out.state = ST_READY;
				end
			end
			FN_SCHED: begin
			end
			FN_WRITE: begin
				if (32'(item.task_index) == 32'(step)) begin
					entry_out.state = item.new_state;
					entry_out.prio  = item.new_priority;
				end
			end
			FN_SLEEP: begin
				if (step == last) begin
					entry_out.state = ST_DELAYED;
					entry_out.ticks = item.sleep_ticks;
				end
			end
			default: begin
			end
		endcase
	end

	// order: priority level, then entries after last before the wrapped ones
	always_comb begin
		runnable  = entry_in.state == ST_READY || entry_in.state == ST_UNRUN;
		eligible  = runnable && (!ctl.priority_mode || 32'(entry_in.prio) < PRIORITY_LEVELS);
		key       = {ctl.priority_mode ? entry_in.prio : 3'd0, step <= last};
		found_eff = ctl.first ? 1'b0 : found_q;
		take      = ctl.scan && item.func == FN_SCHED && eligible &&
		            (!found_eff || key < best_key_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.scan) begin
			found_q <= found_eff || take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_key_q <= key;
			best_idx_q <= step;
		end
	end

	assign found = found_q;
	assign pick  = best_idx_q;

endmodule

[sv/task_scheduler_with_sleep_ticks.sv]
// ----------------------------------------------------------------------------
// task_scheduler_with_sleep_ticks: task table with tick, sleep and scheduling
// The table is a ring of cells that rotates one entry per cycle past an
// update unit; one rotation serves one item.
// ----------------------------------------------------------------------------
// An item is taken only while the block is idle and occupies it through an
// accepting step, one rotation of the ring of entries past the single update
// unit, and a finishing step, where the picked entry is marked ready and the
// result enters the output register. The finishing step waits while an
// earlier result is still stalled. The output register holds one result, so
// the next item is accepted while it waits. Configuration writes must be done
// while no item is in flight.
module task_scheduler_with_sleep_ticks #(
	parameter int TASK_COUNT      = 16,
	parameter int PRIORITY_LEVELS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  tss_pkg::in_t                    in,
	output logic                            out_valid,
	input  logic                            out_stall,
	output tss_pkg::out_t                   out,
	input  logic                            cfg_we,
	input  logic [tss_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic                            cfg_data
);
	import tss_pkg::*;

	localparam int IW = $clog2(TASK_COUNT);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]      state_q;
	logic [IW-1:0]   step_q;
	logic [IW-1:0]   last_q;
	in_t             item_q;
	out_t            out_q;
	logic            out_valid_q;
	logic            priority_mode_q;
	logic            preempt_enable_q;

	entry_t          cell_e [TASK_COUNT];
	entry_t          head_out;
	head_ctl_t       ctl;
	logic            found;
	logic [IW-1:0]   pick;
	logic            shift;
	logic            finish;
	logic            picked;
	logic [TASK_COUNT-1:0] set_ready;
	out_t            result;

	assign shift  = state_q == S_RUN;
	assign finish = state_q == S_DONE && (!out_valid_q || !out_stall);
	assign picked = finish && item_q.func == FN_SCHED && found;

	assign ctl.scan          = shift;
	assign ctl.first         = step_q == '0;
	assign ctl.priority_mode = priority_mode_q;

	genvar i;
	generate
		for (i = 0; i < TASK_COUNT; i++) begin : g_cell
			entry_t nxt;
			if (i == TASK_COUNT - 1) begin : g_tail
				assign nxt = head_out;
			end else begin : g_mid
				assign nxt = cell_e[i+1];
			end
			assign set_ready[i] = picked && pick == IW'(i);
			tss_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.shift     (shift),
				.set_ready (set_ready[i]),
				.next      (nxt),
				.entry     (cell_e[i])
			);
		end
	endgenerate

	tss_head #(
		.TASK_COUNT      (TASK_COUNT),
		.PRIORITY_LEVELS (PRIORITY_LEVELS)
	) u_head (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.item      (item_q),
		.step      (step_q),
		.last      (last_q),
		.entry_in  (cell_e[0]),
		.entry_out (head_out),
		.found     (found),
		.pick      (pick)
	);

	always_comb begin
		result = '0;
		unique case (item_q.func)
			FN_TICK: begin
				result.switch_request = preempt_enable_q;
			end
			FN_SCHED: begin
				result.chosen_task  = found ? 4'(pick) : 4'd0;
				result.chosen_valid = found;
				result.none_ready   = !found;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			priority_mode_q  <= 1'b1;
			preempt_enable_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PRIORITY_MODE: priority_mode_q  <= cfg_data;
				CFG_PREEMPT:       preempt_enable_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			last_q      <= IW'(TASK_COUNT - 1);
			out_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_RUN;
						step_q  <= '0;
					end
				end
				S_RUN: begin
					if (step_q == IW'(TASK_COUNT - 1)) begin
						state_q <= S_DONE;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_DONE: begin
					if (finish) begin
						state_q <= S_IDLE;
						if (picked) last_q <= pick;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) item_q <= in;
		if (finish) out_q <= result;
	end

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign out       = out_q;

	// a new result is only ever loaded by the finishing step
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result appeared outside the finishing step");

	a_one_pick: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(set_ready))
		else $error("more than one entry marked ready");

	a_pick_needs_sched: assert property (@(posedge clk) disable iff (!arst_n)
		(set_ready != '0) |-> (item_q.func == FN_SCHED && found))
		else $error("entry marked ready without a schedule pick");

	a_last_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(last_q) < TASK_COUNT)
		else $error("last dispatched index out of range");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.chosen_valid && out_q.none_ready))
		else $error("result both found and none ready");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the task scheduler with sleep ticks
// Drives write, sleep, tick and schedule items through the valid/stall
// channel, mirrors the task table in a local predictor and checks every
// result in order. Directed checks come first, then random phases with
// sender gaps and receiver stalls under each configuration.
// ----------------------------------------------------------------------------
module tb_top;
	import tss_pkg::*;

	localparam int TASK_COUNT      = 16;
	localparam int PRIORITY_LEVELS = 8;
	localparam int QUIET_LIMIT     = 4000;
	localparam int SETTLE_CYCLES   = TASK_COUNT + 6;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   in_valid  = 1'b0;
	logic                   in_stall;
	in_t                    sched_in  = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	out_t                   sched_out;
	logic                   cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic                   cfg_data  = 1'b0;

	// mirror of the task table and the mode registers
	logic [2:0]  tt_state [TASK_COUNT] = '{default: '0};
	logic [2:0]  tt_prio  [TASK_COUNT] = '{default: '0};
	logic [31:0] tt_ticks [TASK_COUNT] = '{default: '0};
	int          last_run     = TASK_COUNT - 1;
	logic        mode_prio    = 1'b1;
	logic        mode_preempt = 1'b0;

	out_t expected_picks [$];
	int   fail_count     = 0;
	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	int   quiet_cycles   = 0;

	always #10 clk = ~clk;

	task_scheduler_with_sleep_ticks #(
		.TASK_COUNT      (TASK_COUNT),
		.PRIORITY_LEVELS (PRIORITY_LEVELS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in        (sched_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out       (sched_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// circular scan starting after the last dispatched task, prio < 0 takes any
	function automatic bit scan_ring(input int prio, output int pick);
		int t;
		int k;
		t = last_run;
		pick = 0;
		for (k = 0; k < TASK_COUNT; k++) begin
			t = (t + 1) % TASK_COUNT;
			if ((tt_state[t] == ST_READY || tt_state[t] == ST_UNRUN) &&
			    (prio < 0 || int'(tt_prio[t]) == prio)) begin
				pick = t;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic out_t run_task_table(input in_t it);
		out_t r;
		int   i;
		int   p;
		int   pick;
		int   lim;
		bit   found;
		r = '0;
		found = 1'b0;
		pick = 0;
		case (it.func)
			FN_TICK: begin
				lim = (TICKED_TASKS < TASK_COUNT) ? TICKED_TASKS : TASK_COUNT;
				for (i = 0; i < lim; i++) begin
					if (tt_state[i] == ST_DELAYED) begin
						if (tt_ticks[i] != 0)
							tt_ticks[i] = tt_ticks[i] - 1;
						if (tt_ticks[i] == 0)
							tt_state[i] = ST_READY;
					end
				end
				r.switch_request = mode_preempt;
			end
			FN_SCHED: begin
				if (mode_prio) begin
					for (p = 0; p < PRIORITY_LEVELS && !found; p++)
						found = scan_ring(p, pick);
				end else begin
					found = scan_ring(-1, pick);
				end
				if (found) begin
					tt_state[pick] = ST_READY;
					last_run = pick;
					r.chosen_task = pick[3:0];
					r.chosen_valid = 1'b1;
				end else begin
					r.none_ready = 1'b1;
				end
			end
			FN_WRITE: begin
				if (it.task_index < TASK_COUNT) begin
					tt_state[it.task_index] = it.new_state;
					tt_prio[it.task_index] = it.new_priority;
				end
			end
			default: begin
				tt_state[last_run % TASK_COUNT] = ST_DELAYED;
				tt_ticks[last_run % TASK_COUNT] = it.sleep_ticks;
			end
		endcase
		return r;
	endfunction

	task automatic report_bad(input string what, input int unsigned want,
	                          input int unsigned got);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
	endtask

	// result checker, receiver stall and watchdog
	always @(posedge clk) begin
		out_t want;
		if (out_valid && !out_stall) begin
			if (expected_picks.size() == 0) begin
				report_bad("result with no pending item", 32'd0, 32'(sched_out));
			end else begin
				want = expected_picks.pop_front();
				if (sched_out.chosen_task !== want.chosen_task)
					report_bad("chosen_task", 32'(want.chosen_task),
						32'(sched_out.chosen_task));
				if (sched_out.chosen_valid !== want.chosen_valid)
					report_bad("chosen_valid", 32'(want.chosen_valid),
						32'(sched_out.chosen_valid));
				if (sched_out.none_ready !== want.none_ready)
					report_bad("none_ready", 32'(want.none_ready),
						32'(sched_out.none_ready));
				if (sched_out.switch_request !== want.switch_request)
					report_bad("switch_request", 32'(want.switch_request),
						32'(sched_out.switch_request));
			end
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic send_op(input logic [1:0] fn, input logic [3:0] idx,
	                       input logic [2:0] st, input logic [2:0] pr,
	                       input logic [31:0] tk);
		in_t it;
		it.func = fn;
		it.task_index = idx;
		it.new_state = st;
		it.new_priority = pr;
		it.sleep_ticks = tk;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		sched_in <= it;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		expected_picks.push_back(run_task_table(it));
	endtask

	// hold the sender until every pending result is back, then let it settle
	task automatic drain;
		in_valid <= 1'b0;
		while (expected_picks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_modes(input logic pm, input logic pe);
		cfg_we <= 1'b1;
		cfg_index <= CFG_PRIORITY_MODE;
		cfg_data <= pm;
		@(posedge clk);
		cfg_index <= CFG_PREEMPT;
		cfg_data <= pe;
		@(posedge clk);
		cfg_we <= 1'b0;
		mode_prio = pm;
		mode_preempt = pe;
	endtask

	task automatic test_empty_table;
		send_op(FN_SCHED, 4'd0, ST_INVALID, 3'd0, 32'd0);
		send_op(FN_TICK, 4'd0, ST_INVALID, 3'd0, 32'd0);
	endtask

	task automatic test_priority_pick;
		send_op(FN_WRITE, 4'd0, ST_UNRUN, 3'd3, 32'd0);
		send_op(FN_WRITE, 4'd15, ST_READY, 3'd7, 32'd0);
		// unused state code is stored but never picked
		send_op(FN_WRITE, 4'd5, 3'd7, 3'd0, 32'd0);
		send_op(FN_WRITE, 4'd9, ST_READY, 3'd3, 32'd0);
		repeat (3) send_op(FN_SCHED, 4'd0, ST_INVALID, 3'd0, 32'd0);
	endtask

	task automatic test_sleep_and_tick;
		send_op(FN_SLEEP, 4'd0, ST_INVALID, 3'd0, 32'd2);
		send_op(FN_SCHED, 4'd0, ST_INVALID, 3'd0, 32'd0);
		// zero count wakes on the next tick
		send_op(FN_SLEEP, 4'd0, ST_INVALID, 3'd0, 32'd0);
		send_op(FN_TICK, 4'd0, ST_INVALID, 3'd0, 32'd0);
		send_op(FN_TICK, 4'd0, ST_INVALID, 3'd0, 32'd0);
		// entries past the ticked range never count down
		send_op(FN_WRITE, 4'd14, ST_READY, 3'd0, 32'd0);
		send_op(FN_SCHED, 4'd0, ST_INVALID, 3'd0, 32'd0);
		send_op(FN_SLEEP, 4'd0, ST_INVALID, 3'd0, 32'hFFFF_FFFF);
		send_op(FN_TICK, 4'd0, ST_INVALID, 3'd0, 32'd0);
		send_op(FN_SCHED, 4'd0, ST_INVALID, 3'd0, 32'd0);
	endtask

	task automatic test_round_robin_preempt;
		drain();
		set_modes(1'b0, 1'b1);
		send_op(FN_TICK, 4'd0, ST_INVALID, 3'd0, 32'd0);
		send_op(FN_WRITE, 4'd15, ST_INVALID, 3'd5, 32'd0);
		send_op(FN_SCHED, 4'd0, ST_INVALID, 3'd0, 32'd0);
		send_op(FN_SCHED, 4'd0, ST_INVALID, 3'd0, 32'd0);
		send_op(FN_SCHED, 4'd0, ST_INVALID, 3'd0, 32'd0);
	endtask

	task automatic send_random_item;
		int          r;
		logic [2:0]  st;
		logic [31:0] tk;
		r = $urandom_range(99);
		if (r < 30) begin
			// mostly states that the scheduler and the tick act on
			if ($urandom_range(9) < 7)
				st = ST_UNRUN + 3'($urandom_range(2));
			else
				st = 3'($urandom_range(7));
			send_op(FN_WRITE, 4'($urandom_range(15)), st, 3'($urandom_range(7)),
				$urandom);
		end else if (r < 55) begin
			send_op(FN_SCHED, 4'($urandom_range(15)), 3'($urandom_range(7)),
				3'($urandom_range(7)), $urandom);
		end else if (r < 77) begin
			send_op(FN_TICK, 4'($urandom_range(15)), 3'($urandom_range(7)),
				3'($urandom_range(7)), $urandom);
		end else begin
			tk = ($urandom_range(9) < 8) ? 32'($urandom_range(4)) : $urandom;
			send_op(FN_SLEEP, 4'($urandom_range(15)), 3'($urandom_range(7)),
				3'($urandom_range(7)), tk);
		end
	endtask

	task automatic run_random_phase(input int n, input int s_pct, input int r_pct,
	                                input logic pm, input logic pe);
		drain();
		set_modes(pm, pe);
		send_idle_pct = s_pct;
		recv_stall_pct = r_pct;
		repeat (n) send_random_item();
	endtask

	task automatic test_random_steady;
		run_random_phase(125, 0, 0, 1'b1, 1'b0);
	endtask

	task automatic test_random_sender_gaps;
		run_random_phase(125, 73, 0, 1'b0, 1'b1);
	endtask

	task automatic test_random_receiver_stalls;
		run_random_phase(125, 0, 73, 1'b1, 1'b1);
	endtask

	task automatic test_random_both;
		run_random_phase(125, 37, 37, 1'b0, 1'b0);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_priority_pick();
		test_sleep_and_tick();
		test_round_robin_preempt();
		test_random_steady();
		test_random_sender_gaps();
		test_random_receiver_stalls();
		test_random_both();
		drain();
		if (expected_picks.size() != 0)
			report_bad("results never returned", expected_picks.size(), 0);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
